// ===== hdl/tga_pkg.sv =====
// Shared types and constants for the TGA stream RLE decoder.
// No dependencies; imported by every module of the block except tga_fifo.
package tga_pkg;

  // Widest pixel, in bytes, and the matching accumulator width
  localparam int unsigned MAX_PIXEL_BYTES = 4;
  localparam int unsigned PIX_W           = 8 * MAX_PIXEL_BYTES;

  // Default queue depths (both must be at least 2)
  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 2;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Status codes
  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_COLOURMAP = 4'd1,
    ST_UNKNOWN   = 4'd2,
    ST_FORBIDDEN = 4'd3,
    ST_ORIGIN    = 4'd4,
    ST_ZEROSIZE  = 4'd5,
    ST_CORNER    = 4'd6,
    ST_ALPHA     = 4'd7,
    ST_DEPTH     = 4'd8,
    ST_OVERRUN   = 4'd9
  } status_e;

  // Pixel formats
  typedef enum logic [1:0] {
    FMT_GREY8 = 2'd0,
    FMT_BGR24 = 2'd1,
    FMT_BGRA32 = 2'd2
  } fmt_e;

  // One input request: a file byte
  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
  } tga_in_t;

  // One result request
  typedef struct packed {
    logic [1:0]       kind;
    logic [PIX_W-1:0] pixel_value;
    logic [7:0]       repeat_count;
    logic [31:0]      pixel_index;
    logic [15:0]      image_width;
    logic [15:0]      image_height;
    logic [1:0]       pixel_format;
    logic [3:0]       status;
    logic             image_done;
  } tga_out_t;

  // Classified event from the front end to the back end
  typedef struct packed {
    kind_e            kind;
    logic [PIX_W-1:0] value;
    logic [7:0]       left;    // pixels left in packet, 1 for uncompressed data
    logic             run;     // run packet in compressed mode
    logic             comp;    // compressed mode
    logic [15:0]      width;
    logic [15:0]      height;
    fmt_e             fmt;
    status_e          status;  // header error code for error events
  } tga_evt_t;

  localparam int unsigned EVT_W = $bits(tga_evt_t);
  localparam int unsigned OUT_W = $bits(tga_out_t);

endpackage

// ===== hdl/tga_fifo.sv =====
// Small register queue with show-ahead read, generic width and depth.
// No package dependency.
module tga_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrOne;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrOne;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntOne;
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue fill count beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

// ===== hdl/tga_front.sv =====
// Front end: parses header bytes, skips the ID field, gathers pixel bytes.
// Depends on tga_pkg; emits one tga_evt_t per header, error or pixel.
module tga_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  tga_pkg::tga_in_t  in_i,
  output logic              evt_valid_o,
  output tga_pkg::tga_evt_t evt_o
);
  import tga_pkg::*;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_ID     = 5'b00010,
    PH_PACKET = 5'b00100,
    PH_PIXEL  = 5'b01000,
    PH_ERROR  = 5'b10000
  } phase_e;

  // Header byte offsets
  localparam logic [4:0] HP_ID_LEN  = 5'd0;
  localparam logic [4:0] HP_CMAP    = 5'd1;
  localparam logic [4:0] HP_TYPE    = 5'd2;
  localparam logic [4:0] HP_XORG_L  = 5'd8;
  localparam logic [4:0] HP_XORG_H  = 5'd9;
  localparam logic [4:0] HP_YORG_L  = 5'd10;
  localparam logic [4:0] HP_YORG_H  = 5'd11;
  localparam logic [4:0] HP_WIDTH_L = 5'd12;
  localparam logic [4:0] HP_WIDTH_H = 5'd13;
  localparam logic [4:0] HP_HGT_L   = 5'd14;
  localparam logic [4:0] HP_HGT_H   = 5'd15;
  localparam logic [4:0] HP_DEPTH   = 5'd16;
  localparam logic [4:0] HP_DESC    = 5'd17;

  // Image type codes
  localparam logic [7:0] TY_NONE    = 8'd0;
  localparam logic [7:0] TY_CMAP    = 8'd1;
  localparam logic [7:0] TY_TC      = 8'd2;
  localparam logic [7:0] TY_GREY    = 8'd3;
  localparam logic [7:0] TY_RLE_CM  = 8'd9;
  localparam logic [7:0] TY_RLE_TC  = 8'd10;
  localparam logic [7:0] TY_RLE_GR  = 8'd11;

  localparam logic [7:0] DEPTH_8  = 8'd8;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  phase_e           phase_q, phase_d, c_phase;
  logic [4:0]       hpos_q, hpos_d, c_hpos;
  logic [7:0]       id_q, id_d, c_id;
  logic             grey_q, grey_d, c_grey;
  logic [15:0]      w_q, w_d, c_w;
  logic [15:0]      h_q, h_d, c_h;
  logic [7:0]       depth_q, depth_d, c_depth;
  logic             comp_q, comp_d, c_comp;
  logic             run_q, run_d, c_run;
  logic [7:0]       ppl_q, ppl_d, c_ppl;
  logic [PIX_W-1:0] acc_q, acc_d, c_acc;
  logic [1:0]       bip_q, bip_d, c_bip;

  logic [7:0]       b;
  logic             sof;
  status_e          err;
  fmt_e             fmt;
  logic [2:0]       bpp;
  logic [PIX_W-1:0] acc_new;
  logic [15:0]      h_new;
  phase_e           data_ph;

  assign b   = in_i.byte_value;
  assign sof = in_i.start_of_file;

  // Start of file restarts from the reset state
  always_comb begin
    c_phase = sof ? PH_HEADER : phase_q;
    c_hpos  = sof ? '0 : hpos_q;
    c_id    = sof ? '0 : id_q;
    c_grey  = sof ? 1'b0 : grey_q;
    c_w     = sof ? '0 : w_q;
    c_h     = sof ? '0 : h_q;
    c_depth = sof ? '0 : depth_q;
    c_comp  = sof ? 1'b0 : comp_q;
    c_run   = sof ? 1'b0 : run_q;
    c_ppl   = sof ? '0 : ppl_q;
    c_acc   = sof ? '0 : acc_q;
    c_bip   = sof ? '0 : bip_q;
  end

  // Format and bytes per pixel from the header fields
  always_comb begin
    if (c_grey) begin
      fmt = FMT_GREY8;
      bpp = 3'd1;
    end else if (c_depth == DEPTH_24) begin
      fmt = FMT_BGR24;
      bpp = 3'd3;
    end else begin
      fmt = FMT_BGRA32;
      bpp = 3'(MAX_PIXEL_BYTES);
    end
  end

  assign acc_new = c_acc | (PIX_W'(b) << {c_bip, 3'b000});
  assign h_new   = {b, c_h[7:0]};

  // Byte classification and state update
  always_comb begin
    phase_d = phase_q;
    hpos_d  = hpos_q;
    id_d    = id_q;
    grey_d  = grey_q;
    w_d     = w_q;
    h_d     = h_q;
    depth_d = depth_q;
    comp_d  = comp_q;
    run_d   = run_q;
    ppl_d   = ppl_q;
    acc_d   = acc_q;
    bip_d   = bip_q;
    err     = ST_OK;
    data_ph = PH_PIXEL;

    evt_valid_o  = 1'b0;
    evt_o.kind   = KIND_HEADER;
    evt_o.value  = '0;
    evt_o.left   = '0;
    evt_o.run    = 1'b0;
    evt_o.comp   = c_comp;
    evt_o.width  = c_w;
    evt_o.height = c_h;
    evt_o.fmt    = fmt;
    evt_o.status = ST_OK;

    if (accept_i) begin
      phase_d = c_phase;
      hpos_d  = c_hpos;
      id_d    = c_id;
      grey_d  = c_grey;
      w_d     = c_w;
      h_d     = c_h;
      depth_d = c_depth;
      comp_d  = c_comp;
      run_d   = c_run;
      ppl_d   = c_ppl;
      acc_d   = c_acc;
      bip_d   = c_bip;

      unique case (c_phase)
        PH_HEADER: begin
          case (c_hpos)
            HP_ID_LEN: id_d = b;
            HP_CMAP: begin
              if (b != 8'd0) err = ST_COLOURMAP;
            end
            HP_TYPE: begin
              case (b) inside
                TY_TC, TY_RLE_TC: begin
                  grey_d = 1'b0;
                  comp_d = (b == TY_RLE_TC);
                end
                TY_GREY, TY_RLE_GR: begin
                  grey_d = 1'b1;
                  comp_d = (b == TY_RLE_GR);
                end
                TY_NONE, TY_CMAP, TY_RLE_CM: err = ST_FORBIDDEN;
                default: err = ST_UNKNOWN;
              endcase
            end
            HP_XORG_L, HP_XORG_H, HP_YORG_L, HP_YORG_H: begin
              if (b != 8'd0) err = ST_ORIGIN;
            end
            HP_WIDTH_L: w_d = {8'd0, b};
            HP_WIDTH_H: w_d = {b, c_w[7:0]};
            HP_HGT_L:   h_d = {8'd0, b};
            HP_HGT_H: begin
              h_d = h_new;
              if (c_w == 16'd0 || h_new == 16'd0) err = ST_ZEROSIZE;
            end
            HP_DEPTH: depth_d = b;
            HP_DESC: begin
              if (b[5:4] != 2'b00) begin
                err = ST_CORNER;
              end else if (b[3:0] != 4'd0) begin
                err = ST_ALPHA;
              end else if (c_grey) begin
                if (c_depth != DEPTH_8) err = ST_DEPTH;
              end else if (c_depth != DEPTH_24 && c_depth != DEPTH_32) begin
                err = ST_DEPTH;
              end
            end
            default: ;
          endcase

          data_ph = comp_d ? PH_PACKET : PH_PIXEL;
          if (err != ST_OK) begin
            phase_d      = PH_ERROR;
            evt_valid_o  = 1'b1;
            evt_o.kind   = KIND_ERROR;
            evt_o.status = err;
          end else if (c_hpos >= HP_DESC) begin
            phase_d     = (id_d != 8'd0) ? PH_ID : data_ph;
            evt_valid_o = 1'b1;
            evt_o.kind  = KIND_HEADER;
          end else begin
            hpos_d = c_hpos + 5'd1;
          end
        end

        // Skip the image ID field
        PH_ID: begin
          id_d = c_id - 8'd1;
          if (id_d == 8'd0) phase_d = c_comp ? PH_PACKET : PH_PIXEL;
        end

        // Packet header: type bit and pixel count
        PH_PACKET: begin
          run_d   = b[7];
          ppl_d   = {1'b0, b[6:0]} + 8'd1;
          bip_d   = '0;
          acc_d   = '0;
          phase_d = PH_PIXEL;
        end

        // Gather pixel bytes, hand a finished pixel to the back end
        PH_PIXEL: begin
          if ({1'b0, c_bip} + 3'd1 < bpp) begin
            acc_d = acc_new;
            bip_d = c_bip + 2'd1;
          end else begin
            acc_d       = '0;
            bip_d       = '0;
            evt_valid_o = 1'b1;
            evt_o.kind  = KIND_PIXEL;
            evt_o.value = acc_new;
            evt_o.left  = c_comp ? c_ppl : 8'd1;
            evt_o.run   = c_comp && c_run;
            if (c_comp) begin
              ppl_d = c_run ? 8'd0 : c_ppl - 8'd1;
              if (ppl_d == 8'd0) phase_d = PH_PACKET;
            end
          end
        end

        PH_ERROR: ;
        default: phase_d = PH_ERROR;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hpos_q  <= '0;
      id_q    <= '0;
      grey_q  <= 1'b0;
      w_q     <= '0;
      h_q     <= '0;
      depth_q <= '0;
      comp_q  <= 1'b0;
      run_q   <= 1'b0;
      ppl_q   <= '0;
      acc_q   <= '0;
      bip_q   <= '0;
    end else begin
      phase_q <= phase_d;
      hpos_q  <= hpos_d;
      id_q    <= id_d;
      grey_q  <= grey_d;
      w_q     <= w_d;
      h_q     <= h_d;
      depth_q <= depth_d;
      comp_q  <= comp_d;
      run_q   <= run_d;
      ppl_q   <= ppl_d;
      acc_q   <= acc_d;
      bip_q   <= bip_d;
    end
  end

  a_hpos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HEADER) |-> (hpos_q <= HP_DESC))
    else $error("header position past descriptor byte");

  a_pixel_from_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_valid_o && evt_o.kind == KIND_PIXEL) |-> (phase_q == PH_PIXEL && !sof))
    else $error("pixel event outside pixel phase");

  a_ppl_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PIXEL && comp_q) |-> (ppl_q != 8'd0))
    else $error("compressed pixel phase with empty packet");

endmodule

// ===== hdl/tga_back.sv =====
// Back end: places pixel events in the image, clips runs, builds results.
// Depends on tga_pkg; takes tga_evt_t, gives tga_out_t.
module tga_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  tga_pkg::tga_evt_t head_i,
  output logic              head_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output tga_pkg::tga_out_t res_o
);
  import tga_pkg::*;

  logic [31:0] total_q, total_d;
  logic [31:0] pos_q, pos_d;
  logic        done_q, done_d;

  logic        is_pix, drop;
  logic [31:0] remaining, left32;
  logic [7:0]  used;
  logic        fin, over;

  assign is_pix = (head_i.kind == KIND_PIXEL);
  // Pixels after the last one are dropped without a result
  assign drop   = is_pix && done_q;

  assign head_pop_o = head_valid_i && (drop || !res_full_i);
  assign res_push_o = head_pop_o && !drop;

  // Run placement and clipping
  assign remaining = total_q - pos_q;
  assign left32    = {24'd0, head_i.left};
  always_comb begin
    if (head_i.run) begin
      used = (left32 < remaining) ? head_i.left : remaining[7:0];
    end else begin
      used = 8'd1;
    end
  end
  assign fin  = ({24'd0, used} >= remaining);
  assign over = head_i.comp && fin && (head_i.left > used);

  // Result formatting
  always_comb begin
    res_o              = '0;
    res_o.kind         = head_i.kind;
    res_o.image_width  = head_i.width;
    res_o.image_height = head_i.height;
    res_o.pixel_format = head_i.fmt;
    case (head_i.kind)
      KIND_PIXEL: begin
        res_o.pixel_value  = head_i.value;
        res_o.repeat_count = used;
        res_o.pixel_index  = pos_q;
        res_o.status       = over ? ST_OVERRUN : ST_OK;
        res_o.image_done   = fin;
      end
      KIND_ERROR: begin
        res_o.image_width  = '0;
        res_o.image_height = '0;
        res_o.pixel_format = '0;
        res_o.status       = head_i.status;
      end
      default: ;
    endcase
  end

  // Image position tracking
  always_comb begin
    total_d = total_q;
    pos_d   = pos_q;
    done_d  = done_q;
    if (head_pop_o) begin
      if (head_i.kind == KIND_HEADER) begin
        total_d = {16'd0, head_i.width} * {16'd0, head_i.height};
        pos_d   = '0;
        done_d  = 1'b0;
      end else if (is_pix && !done_q) begin
        pos_d  = pos_q + {24'd0, used};
        done_d = fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      pos_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      total_q <= total_d;
      pos_q   <= pos_d;
      done_q  <= done_d;
    end
  end

  a_done_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (pos_q == total_q))
    else $error("image marked done away from its last pixel");

  a_overrun_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.status == ST_OVERRUN) |-> res_o.image_done)
    else $error("overrun flagged before the image end");

  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_pop_o && is_pix && !done_q) |=> (pos_q == $past(pos_q) + {24'd0, $past(used)}))
    else $error("pixel position did not advance by the run length");

endmodule

// ===== hdl/tga_stream_rle_decoder_core.sv =====
// Top level of the TGA stream RLE decoder: front end, event queue, back end,
// result queue. Depends on tga_pkg, tga_fifo, tga_front and tga_back.
//
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------
//   input    | push / full      | in_item_i  (tga_in_t, 1 byte)
//   result   | empty / pop      | out_item_o (tga_out_t)
//
// One byte is taken every cycle while full is low; a result reaches the result
// ports through the event queue and then the result queue, both registered.
// Throughput is set by the front parser: one byte per cycle while not full.
// Reset clears every control register at once; no clearing pass.
// A stalled result side fills the result queue, then the event queue, then
// raises full; until then bytes that give no result pass without waiting.
module tga_stream_rle_decoder_core #(
  parameter int unsigned MidDepth = tga_pkg::MID_DEPTH,
  parameter int unsigned OutDepth = tga_pkg::OUT_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  tga_pkg::tga_in_t  in_item_i,
  output logic              empty,
  input  logic              pop,
  output tga_pkg::tga_out_t out_item_o
);
  import tga_pkg::*;

  logic     mid_full, mid_empty, accept;
  logic     evt_valid, head_pop;
  tga_evt_t evt, head;
  logic     res_full, res_push;
  tga_out_t res;

  assign full   = mid_full;
  assign accept = push && !mid_full;

  tga_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_i        (in_item_i),
    .evt_valid_o (evt_valid),
    .evt_o       (evt)
  );

  // Event queue between parser and back end
  tga_fifo #(
    .Width (EVT_W),
    .Depth (MidDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (evt_valid),
    .wdata_i (evt),
    .full_o  (mid_full),
    .pop_i   (head_pop),
    .rdata_o (head),
    .empty_o (mid_empty)
  );

  tga_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!mid_empty),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  // Result queue towards the consumer
  tga_fifo #(
    .Width (OUT_W),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

  a_evt_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid |-> !mid_full || !accept)
    else $error("event produced into a full queue");

  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |-> !mid_empty)
    else $error("back end took an event from an empty queue");

endmodule
